### rtl/cmsc_pkg.sv
// ----------------------------------------------------------------------------
// cmsc_pkg
// Shared types and constants for the cooked mesh stream checker: payload
// structs, configuration bundle, header layout, status codes and helpers.
// ----------------------------------------------------------------------------
package cmsc_pkg;

  // input transaction payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_pkt_t;

  // result transaction payload
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] mesh_kind;
    logic [31:0] vert_cnt;
    logic [31:0] idx_cnt;
    logic [63:0] fingerprint;
  } out_pkt_t;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic [20:0] max_vertices;
    logic [22:0] max_indices;
    logic [25:0] max_bytes;
    logic [7:0]  hull_kind_code;
    logic [7:0]  mesh_kind_code;
  } cfg_t;

  // per-file snapshot handed from the parser to the status stage
  typedef struct packed {
    logic [63:0] hash;
    logic [63:0] stored_sum;
    logic [63:0] stored_size;
    logic [63:0] stored_print;
    logic [31:0] kind;
    logic [31:0] vert;
    logic [31:0] idx;
    logic        magic_ok;
    logic        len_ovf;
    logic        vert_err;
    logic        idx_err;
  } fin_t;

  // result status codes, lowest failing check wins
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_HEADER = 3'd1,
    ST_DIMS   = 3'd2,
    ST_VERTEX = 3'd3,
    ST_INDEX  = 3'd4
  } status_t;

  // configuration register indexes
  localparam logic [2:0] CFG_MAX_VERTICES = 3'd0;
  localparam logic [2:0] CFG_MAX_INDICES  = 3'd1;
  localparam logic [2:0] CFG_MAX_BYTES    = 3'd2;
  localparam logic [2:0] CFG_HULL_KIND    = 3'd3;
  localparam logic [2:0] CFG_MESH_KIND    = 3'd4;

  // configuration reset values
  localparam logic [20:0] MAX_VERTICES_RST = 21'd65536;
  localparam logic [22:0] MAX_INDICES_RST  = 23'd196608;
  localparam logic [25:0] MAX_BYTES_RST    = 26'd33554432;
  localparam logic [7:0]  HULL_KIND_RST    = 8'd0;
  localparam logic [7:0]  MESH_KIND_RST    = 8'd1;

  // hash constants
  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;

  // header layout, offsets of the last byte of each word
  localparam int          HEADER_BYTES = 48;
  localparam int          SUM_LO       = 24;
  localparam int          SUM_HI       = 32;
  localparam logic [5:0]  OFF_MAGIC    = 6'd3;
  localparam logic [5:0]  OFF_VERSION  = 6'd7;
  localparam logic [5:0]  OFF_SIZE     = 6'd15;
  localparam logic [5:0]  OFF_PRINT    = 6'd23;
  localparam logic [5:0]  OFF_SUM      = 6'd31;
  localparam logic [5:0]  OFF_KIND     = 6'd35;
  localparam logic [5:0]  OFF_VERT     = 6'd39;
  localparam logic [5:0]  OFF_IDX      = 6'd43;
  localparam logic [5:0]  OFF_RSVD     = 6'd47;

  localparam logic [31:0] MAGIC_WORD   = 32'h31434B56;
  localparam logic [31:0] VERSION_WORD = 32'd1;
  localparam logic [30:0] COORD_LIMIT  = 31'h4B189680;

  // true when the value is a multiple of three (base-4 digit sums)
  function automatic logic is_mult3(input logic [31:0] val);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [2:0] s3;
    s1 = '0;
    for (int i = 0; i < 16; i++) begin
      s1 = s1 + 6'(val[2*i +: 2]);
    end
    s2 = 4'(s1[1:0]) + 4'(s1[3:2]) + 4'(s1[5:4]);
    s3 = 3'(s2[1:0]) + 3'(s2[3:2]);
    return (s3 == 3'd0) || (s3 == 3'd3);
  endfunction

endpackage

### rtl/cooked_mesh_stream_checker_top.sv
// ----------------------------------------------------------------------------
// cooked_mesh_stream_checker_top
// Streaming checker for cooked collision-mesh files: hash, header, dimension
// and payload checks with one status transaction per file.
// ----------------------------------------------------------------------------
// The block takes one file byte per clock cycle unless in_stall holds it,
// and gives one result transaction when the byte marked last has been taken;
// that result passes through the parser's snapshot register and the result
// register to out_valid. The rate is set by the 64-bit hash recurrence, one
// multiply-by-prime (shifts and adds) per byte in the parser. Three stages:
// an input register, the parser with its per-file state, and the status
// stage with the result register. Configuration writes take effect on the
// next cycle; there is no clearing pass after reset.
module cooked_mesh_stream_checker_top
  import cmsc_pkg::*;
#(
  parameter int POSITION_BITS   = 26,
  parameter int HULL_VERTEX_CAP = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_pkt_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_pkt_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [25:0] cfg_wdata
);

  cfg_t                     cfg_r;
  logic                     in_vld_r;
  in_pkt_t                  in_r;
  logic                     s1_free;
  logic                     step;
  logic                     fin_vld;
  logic                     fin_take;
  fin_t                     fin;
  logic [POSITION_BITS-1:0] fin_size;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_vertices   <= MAX_VERTICES_RST;
      cfg_r.max_indices    <= MAX_INDICES_RST;
      cfg_r.max_bytes      <= MAX_BYTES_RST;
      cfg_r.hull_kind_code <= HULL_KIND_RST;
      cfg_r.mesh_kind_code <= MESH_KIND_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MAX_VERTICES: cfg_r.max_vertices   <= cfg_wdata[20:0];
        CFG_MAX_INDICES:  cfg_r.max_indices    <= cfg_wdata[22:0];
        CFG_MAX_BYTES:    cfg_r.max_bytes      <= cfg_wdata;
        CFG_HULL_KIND:    cfg_r.hull_kind_code <= cfg_wdata[7:0];
        CFG_MESH_KIND:    cfg_r.mesh_kind_code <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // input stage handshake, a final byte waits for a free snapshot slot
  assign step     = in_vld_r && (!in_r.last || !fin_vld || fin_take);
  assign s1_free  = !in_vld_r || step;
  assign in_stall = !s1_free;

  // input register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (s1_free) begin
      in_vld_r <= in_valid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_valid && s1_free) begin
      in_r <= in_data;
    end
  end

  // per-byte parser
  cmsc_parse #(
    .POSITION_BITS (POSITION_BITS)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .step     (step),
    .pkt      (in_r),
    .fin_take (fin_take),
    .fin_vld  (fin_vld),
    .fin      (fin),
    .fin_size (fin_size)
  );

  // status evaluation and result register
  cmsc_judge #(
    .POSITION_BITS   (POSITION_BITS),
    .HULL_VERTEX_CAP (HULL_VERTEX_CAP)
  ) u_judge (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .fin_vld   (fin_vld),
    .fin       (fin),
    .fin_size  (fin_size),
    .fin_take  (fin_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### rtl/cmsc_parse.sv
// ----------------------------------------------------------------------------
// cmsc_parse
// Per-byte core: running hash, byte counter, header decode and payload
// coordinate and index checks. On the final byte it hands a snapshot of the
// file state to the status stage and clears itself for the next file.
// ----------------------------------------------------------------------------
module cmsc_parse
  import cmsc_pkg::*;
#(
  parameter int POSITION_BITS = 26
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  logic                     step,
  input  in_pkt_t                  pkt,
  input  logic                     fin_take,
  output logic                     fin_vld,
  output fin_t                     fin,
  output logic [POSITION_BITS-1:0] fin_size
);

  localparam int PW = POSITION_BITS;
  localparam int CW = (PW > 26) ? PW : 26;
  localparam int WW = (PW > 35) ? PW : 35;

  // file state
  logic [63:0]   hash_r,   hash_nxt;
  logic [PW-1:0] pos_r,    pos_nxt;
  logic          ovf_r,    ovf_nxt;
  logic [63:0]   shift_r,  shift_nxt;
  logic          magic_r,  magic_nxt;
  logic [63:0]   ssize_r,  ssize_nxt;
  logic [63:0]   ssum_r,   ssum_nxt;
  logic [63:0]   sprint_r, sprint_nxt;
  logic [31:0]   kind_r,   kind_nxt;
  logic [31:0]   vert_r,   vert_nxt;
  logic [31:0]   idx_r,    idx_nxt;
  logic          verr_r,   verr_nxt;
  logic          ierr_r,   ierr_nxt;

  // snapshot register
  logic          fin_vld_r;
  fin_t          fin_r;
  logic [PW-1:0] fin_size_r;

  logic [7:0]    byte_x;
  logic [63:0]   hx;
  logic [31:0]   w32;
  logic          in_hdr;
  logic [PW-1:0] pos_off;
  logic [WW-1:0] word_idx;
  logic [WW-1:0] coords;
  logic [WW-1:0] idx_end;
  logic          pos_full;
  logic [PW-1:0] size_nxt;
  logic          clr;

  // hash update, checksum bytes count as zero
  always_comb begin
    byte_x = ((pos_r < PW'(SUM_LO)) || (pos_r >= PW'(SUM_HI))) ? pkt.data_byte : 8'h00;
    hx     = hash_r ^ {56'h0, byte_x};
    hash_nxt = hx + (hx << 1) + (hx << 4) + (hx << 5) + (hx << 7) + (hx << 8)
             + (hx << 40);
  end

  // byte counter with saturation and overflow flag
  always_comb begin
    pos_full = &pos_r;
    size_nxt = pos_full ? pos_r : pos_r + PW'(1);
    pos_nxt  = size_nxt;
    ovf_nxt  = ovf_r | pos_full | (CW'(size_nxt) > CW'(cfg.max_bytes));
  end

  // header decode and payload checks on each completed word
  always_comb begin
    shift_nxt  = {pkt.data_byte, shift_r[63:8]};
    w32        = shift_nxt[63:32];
    in_hdr     = pos_r < PW'(HEADER_BYTES);
    pos_off    = pos_r - PW'(HEADER_BYTES);
    word_idx   = WW'(pos_off[PW-1:2]);
    coords     = WW'({2'b00, vert_r}) + WW'({1'b0, vert_r, 1'b0});
    idx_end    = coords + WW'(idx_r);
    magic_nxt  = magic_r;
    ssize_nxt  = ssize_r;
    ssum_nxt   = ssum_r;
    sprint_nxt = sprint_r;
    kind_nxt   = kind_r;
    vert_nxt   = vert_r;
    idx_nxt    = idx_r;
    verr_nxt   = verr_r;
    ierr_nxt   = ierr_r;
    if (in_hdr) begin
      case (pos_r[5:0])
        OFF_MAGIC:   if (w32 != MAGIC_WORD) magic_nxt = 1'b0;
        OFF_VERSION: if (w32 != VERSION_WORD) magic_nxt = 1'b0;
        OFF_SIZE:    ssize_nxt = shift_nxt;
        OFF_PRINT:   sprint_nxt = shift_nxt;
        OFF_SUM:     ssum_nxt = shift_nxt;
        OFF_KIND:    kind_nxt = w32;
        OFF_VERT:    vert_nxt = w32;
        OFF_IDX:     idx_nxt = w32;
        OFF_RSVD:    if (w32 != 32'h0) magic_nxt = 1'b0;
        default: ;
      endcase
    end else if (pos_r[1:0] == 2'b11) begin
      if (word_idx < coords) begin
        if (w32[30:0] > COORD_LIMIT) verr_nxt = 1'b1;
      end else if (word_idx < idx_end) begin
        if (w32 >= vert_r) ierr_nxt = 1'b1;
      end
    end
  end

  assign clr = !rst_n || (step && pkt.last);

  // file state registers, cleared by reset and after each final byte
  always_ff @(posedge clk) begin
    if (clr) begin
      hash_r   <= FNV_BASIS;
      pos_r    <= '0;
      ovf_r    <= 1'b0;
      shift_r  <= '0;
      magic_r  <= 1'b1;
      ssize_r  <= '0;
      ssum_r   <= '0;
      sprint_r <= '0;
      kind_r   <= '0;
      vert_r   <= '0;
      idx_r    <= '0;
      verr_r   <= 1'b0;
      ierr_r   <= 1'b0;
    end else if (step) begin
      hash_r   <= hash_nxt;
      pos_r    <= pos_nxt;
      ovf_r    <= ovf_nxt;
      shift_r  <= shift_nxt;
      magic_r  <= magic_nxt;
      ssize_r  <= ssize_nxt;
      ssum_r   <= ssum_nxt;
      sprint_r <= sprint_nxt;
      kind_r   <= kind_nxt;
      vert_r   <= vert_nxt;
      idx_r    <= idx_nxt;
      verr_r   <= verr_nxt;
      ierr_r   <= ierr_nxt;
    end
  end

  // snapshot valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (step && pkt.last) begin
      fin_vld_r <= 1'b1;
    end else if (fin_take) begin
      fin_vld_r <= 1'b0;
    end
  end

  // snapshot payload
  always_ff @(posedge clk) begin
    if (step && pkt.last) begin
      fin_r.hash         <= hash_nxt;
      fin_r.stored_sum   <= ssum_nxt;
      fin_r.stored_size  <= ssize_nxt;
      fin_r.stored_print <= sprint_nxt;
      fin_r.kind         <= kind_nxt;
      fin_r.vert         <= vert_nxt;
      fin_r.idx          <= idx_nxt;
      fin_r.magic_ok     <= magic_nxt;
      fin_r.len_ovf      <= ovf_nxt;
      fin_r.vert_err     <= verr_nxt;
      fin_r.idx_err      <= ierr_nxt;
      fin_size_r         <= size_nxt;
    end
  end

  assign fin_vld  = fin_vld_r;
  assign fin      = fin_r;
  assign fin_size = fin_size_r;

endmodule

### rtl/cmsc_judge.sv
// ----------------------------------------------------------------------------
// cmsc_judge
// Status stage: evaluates header, dimension and payload checks on a file
// snapshot in priority order and holds the result transaction.
// ----------------------------------------------------------------------------
module cmsc_judge
  import cmsc_pkg::*;
#(
  parameter int POSITION_BITS   = 26,
  parameter int HULL_VERTEX_CAP = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  logic                     fin_vld,
  input  fin_t                     fin,
  input  logic [POSITION_BITS-1:0] fin_size,
  output logic                     fin_take,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_pkt_t                 out_data
);

  localparam int PW = POSITION_BITS;
  localparam int DW = (PW > 38) ? PW : 38;

  logic          out_vld_r;
  out_pkt_t      out_r;
  out_pkt_t      res;
  status_t       st;
  logic [63:0]   size64;
  logic [DW-1:0] exp_size;
  logic          is_hull;
  logic          is_mesh;
  logic          hdr_bad;
  logic          dims_bad;

  // checks in priority order
  always_comb begin
    size64   = 64'(fin_size);
    exp_size = DW'(HEADER_BYTES) + DW'({fin.vert, 3'b000}) + DW'({fin.vert, 2'b00})
             + DW'({fin.idx, 2'b00});
    is_hull  = fin.kind == {24'h0, cfg.hull_kind_code};
    is_mesh  = fin.kind == {24'h0, cfg.mesh_kind_code};
    hdr_bad  = (size64 < 64'(HEADER_BYTES)) || fin.len_ovf
            || (size64 > 64'(cfg.max_bytes)) || !fin.magic_ok
            || (fin.stored_size != size64) || (fin.hash != fin.stored_sum);
    dims_bad = (fin.vert < 32'd3) || (fin.vert > 32'(cfg.max_vertices))
            || (fin.idx < 32'd3) || (fin.idx > 32'(cfg.max_indices))
            || !is_mult3(fin.idx) || (!is_hull && !is_mesh)
            || (is_hull && ((fin.vert < 32'd4) || (fin.vert > 32'(HULL_VERTEX_CAP))))
            || (64'(exp_size) != size64);
    if (hdr_bad) begin
      st = ST_HEADER;
    end else if (dims_bad) begin
      st = ST_DIMS;
    end else if (fin.vert_err) begin
      st = ST_VERTEX;
    end else if (fin.idx_err) begin
      st = ST_INDEX;
    end else begin
      st = ST_OK;
    end
    res.status      = st;
    res.mesh_kind   = fin.kind;
    res.vert_cnt    = fin.vert;
    res.idx_cnt     = fin.idx;
    res.fingerprint = fin.stored_print;
  end

  assign fin_take = fin_vld && (!out_vld_r || !out_stall);

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fin_take) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fin_take) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
